// ===== design/tfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Timecode frame arithmetic package
// Shared types, codes and per-rate constant tables.
// ----------------------------------------------------------------------------
package tfa_pkg;

  // Rate codes.
  localparam logic [2:0] RATE_24    = 3'd0;
  localparam logic [2:0] RATE_25    = 3'd1;
  localparam logic [2:0] RATE_30    = 3'd2;
  localparam logic [2:0] RATE_60    = 3'd3;
  localparam logic [2:0] RATE_D2997 = 3'd4;
  localparam logic [2:0] RATE_D5994 = 3'd5;
  localparam logic [2:0] RATE_RESET = RATE_30;

  // Command codes.
  localparam logic [1:0] CMD_ADD_TC  = 2'd0;
  localparam logic [1:0] CMD_ADD_OFS = 2'd1;
  localparam logic [1:0] CMD_DIFF    = 2'd2;

  // Day wrap codes.
  localparam logic [1:0] WRAP_NONE  = 2'd0;
  localparam logic [1:0] WRAP_OVER  = 2'd1;
  localparam logic [1:0] WRAP_UNDER = 2'd2;

  // Reciprocal shifts; each is large enough that the product rounds exactly.
  localparam int DAY_SH = 55;
  localparam int HR_SH  = 41;
  localparam int MIN_SH = 34;
  localparam int DM_SH  = 28;
  localparam int SEC_SH = 18;

  // Nominal frames per second.
  localparam logic [6:0] FPS [8] = '{7'd24, 7'd25, 7'd30, 7'd60, 7'd30, 7'd60, 7'd30, 7'd30};

  // Frames per hour.
  localparam logic [17:0] FPH [8] = '{18'd86400, 18'd90000, 18'd108000, 18'd216000,
                                      18'd107892, 18'd215784, 18'd108000, 18'd108000};

  // Frames per day.
  localparam logic [22:0] DAY [8] = '{23'd2073600, 23'd2160000, 23'd2592000, 23'd5184000,
                                      23'd2589408, 23'd5178816, 23'd2592000, 23'd2592000};

  // Frames per minute (non-drop) or per ten-minute block (drop).
  localparam logic [15:0] D2 [8] = '{16'd1440, 16'd1500, 16'd1800, 16'd3600,
                                     16'd17982, 16'd35964, 16'd1800, 16'd1800};

  // Frames in a dropped minute.
  localparam logic [11:0] D3 [8] = '{12'd1798, 12'd1798, 12'd1798, 12'd1798,
                                     12'd1798, 12'd3596, 12'd1798, 12'd1798};

  localparam logic [34:0] M_DAY [8] = '{
    35'((67'd1 << DAY_SH) / 67'd2073600 + 67'd1),
    35'((67'd1 << DAY_SH) / 67'd2160000 + 67'd1),
    35'((67'd1 << DAY_SH) / 67'd2592000 + 67'd1),
    35'((67'd1 << DAY_SH) / 67'd5184000 + 67'd1),
    35'((67'd1 << DAY_SH) / 67'd2589408 + 67'd1),
    35'((67'd1 << DAY_SH) / 67'd5178816 + 67'd1),
    35'((67'd1 << DAY_SH) / 67'd2592000 + 67'd1),
    35'((67'd1 << DAY_SH) / 67'd2592000 + 67'd1)};

  localparam logic [24:0] M_HR [8] = '{
    25'((48'd1 << HR_SH) / 48'd86400 + 48'd1),
    25'((48'd1 << HR_SH) / 48'd90000 + 48'd1),
    25'((48'd1 << HR_SH) / 48'd108000 + 48'd1),
    25'((48'd1 << HR_SH) / 48'd216000 + 48'd1),
    25'((48'd1 << HR_SH) / 48'd107892 + 48'd1),
    25'((48'd1 << HR_SH) / 48'd215784 + 48'd1),
    25'((48'd1 << HR_SH) / 48'd108000 + 48'd1),
    25'((48'd1 << HR_SH) / 48'd108000 + 48'd1)};

  localparam logic [23:0] M_MIN [8] = '{
    24'((42'd1 << MIN_SH) / 42'd1440 + 42'd1),
    24'((42'd1 << MIN_SH) / 42'd1500 + 42'd1),
    24'((42'd1 << MIN_SH) / 42'd1800 + 42'd1),
    24'((42'd1 << MIN_SH) / 42'd3600 + 42'd1),
    24'((42'd1 << MIN_SH) / 42'd17982 + 42'd1),
    24'((42'd1 << MIN_SH) / 42'd35964 + 42'd1),
    24'((42'd1 << MIN_SH) / 42'd1800 + 42'd1),
    24'((42'd1 << MIN_SH) / 42'd1800 + 42'd1)};

  localparam logic [17:0] M_DM [8] = '{
    18'((34'd1 << DM_SH) / 34'd1798 + 34'd1),
    18'((34'd1 << DM_SH) / 34'd1798 + 34'd1),
    18'((34'd1 << DM_SH) / 34'd1798 + 34'd1),
    18'((34'd1 << DM_SH) / 34'd1798 + 34'd1),
    18'((34'd1 << DM_SH) / 34'd1798 + 34'd1),
    18'((34'd1 << DM_SH) / 34'd3596 + 34'd1),
    18'((34'd1 << DM_SH) / 34'd1798 + 34'd1),
    18'((34'd1 << DM_SH) / 34'd1798 + 34'd1)};

  localparam logic [13:0] M_SEC [8] = '{
    14'((26'd1 << SEC_SH) / 26'd24 + 26'd1),
    14'((26'd1 << SEC_SH) / 26'd25 + 26'd1),
    14'((26'd1 << SEC_SH) / 26'd30 + 26'd1),
    14'((26'd1 << SEC_SH) / 26'd60 + 26'd1),
    14'((26'd1 << SEC_SH) / 26'd30 + 26'd1),
    14'((26'd1 << SEC_SH) / 26'd60 + 26'd1),
    14'((26'd1 << SEC_SH) / 26'd30 + 26'd1),
    14'((26'd1 << SEC_SH) / 26'd30 + 26'd1)};

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic        vld;
    logic        ok;
    logic [1:0]  cmd;
    logic [2:0]  rate;
    logic [1:0]  wrap;
    logic [23:0] diff;
  } tfa_ctl_t;

  function automatic logic is_drop(logic [2:0] k);
    return (k == RATE_D2997) || (k == RATE_D5994);
  endfunction

endpackage

// ===== design/tfa_front.sv =====
// ----------------------------------------------------------------------------
// Timecode front end
// Checks the timecodes that the command uses, converts them to frame counts and forms the sum and difference.
// ----------------------------------------------------------------------------
module tfa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [2:0]        rate_i,
  input  logic [1:0]        cmd_i,
  input  logic [4:0]        a_hours_i,
  input  logic [5:0]        a_minutes_i,
  input  logic [5:0]        a_seconds_i,
  input  logic [5:0]        a_frames_i,
  input  logic [4:0]        b_hours_i,
  input  logic [5:0]        b_minutes_i,
  input  logic [5:0]        b_seconds_i,
  input  logic [5:0]        b_frames_i,
  input  logic signed [31:0] frame_offset_i,
  output tfa_pkg::tfa_ctl_t ctl_o,
  output logic [31:0]       mag_o,
  output logic              neg_o
);

  function automatic logic [5:0] tens_of(logic [5:0] m);
    logic [13:0] p;
    p = 14'(m) * 14'd205;
    return 6'(p >> 11);
  endfunction

  function automatic logic tc_ok(logic [2:0] k, logic [4:0] h, logic [5:0] m,
                                 logic [5:0] s, logic [5:0] f);
    logic [5:0] mm;
    logic [5:0] dropn;
    logic       good;
    mm    = 6'(m - 6'(tens_of(m) * 6'd10));
    dropn = (k == tfa_pkg::RATE_D5994) ? 6'd4 : 6'd2;
    good  = (k <= tfa_pkg::RATE_D5994) && (h <= 5'd23) && (m <= 6'd59) && (s <= 6'd59) &&
            (7'(f) < tfa_pkg::FPS[k]);
    if (tfa_pkg::is_drop(k) && (s == 6'd0) && (f < dropn) && (mm != 6'd0)) begin
      good = 1'b0;
    end
    return good;
  endfunction

  function automatic logic [22:0] tc_frames(logic [2:0] k, logic [4:0] h, logic [5:0] m,
                                            logic [5:0] s, logic [5:0] f);
    logic [5:0]  tens;
    logic [5:0]  mm;
    logic [22:0] acc;
    tens = tens_of(m);
    mm   = 6'(m - 6'(tens * 6'd10));
    acc  = 23'(23'(h) * 23'(tfa_pkg::FPH[k]));
    if (tfa_pkg::is_drop(k)) begin
      acc = 23'(acc + 23'(tens) * 23'(tfa_pkg::D2[k]) + 23'(mm) * 23'(tfa_pkg::D3[k]));
    end else begin
      acc = 23'(acc + 23'(m) * 23'(tfa_pkg::D2[k]));
    end
    return 23'(acc + 23'(s) * 23'(tfa_pkg::FPS[k]) + 23'(f));
  endfunction

  // Stage 1: check and convert.
  tfa_pkg::tfa_ctl_t c1_d, c1_q;
  logic [22:0]       pa_d, pa_q, pb_d, pb_q;
  logic signed [31:0] ofs_q;

  always_comb begin
    c1_d      = '0;
    c1_d.vld  = vld_i;
    c1_d.cmd  = cmd_i;
    c1_d.rate = rate_i;
    c1_d.ok   = (cmd_i != 2'd3) && tc_ok(rate_i, a_hours_i, a_minutes_i, a_seconds_i, a_frames_i) &&
                ((cmd_i == tfa_pkg::CMD_ADD_OFS) ||
                 tc_ok(rate_i, b_hours_i, b_minutes_i, b_seconds_i, b_frames_i));
    pa_d      = tc_frames(rate_i, a_hours_i, a_minutes_i, a_seconds_i, a_frames_i);
    pb_d      = tc_frames(rate_i, b_hours_i, b_minutes_i, b_seconds_i, b_frames_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
    end else if (en_i) begin
      c1_q <= c1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      ofs_q <= frame_offset_i;
    end
  end

  // Stage 2: sum, wrap direction and magnitude.
  tfa_pkg::tfa_ctl_t c2_d, c2_q;
  logic signed [33:0] sum;
  logic [31:0]        mag_d, mag_q;
  logic               neg_q;

  always_comb begin
    c2_d = c1_q;
    if (c1_q.cmd == tfa_pkg::CMD_ADD_TC) begin
      sum = 34'(pa_q) + 34'(pb_q);
    end else begin
      sum = 34'(ofs_q) + 34'(pa_q);
    end
    if (sum[33]) begin
      c2_d.wrap = tfa_pkg::WRAP_UNDER;
      mag_d     = 32'(-sum);
    end else begin
      c2_d.wrap = ($unsigned(sum) >= 34'(tfa_pkg::DAY[c1_q.rate])) ? tfa_pkg::WRAP_OVER
                                                                   : tfa_pkg::WRAP_NONE;
      mag_d     = 32'(sum);
    end
    c2_d.diff = 24'(pb_q) - 24'(pa_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_q <= '0;
    end else if (en_i) begin
      c2_q <= c2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= sum[33];
    end
  end

  assign ctl_o = c2_q;
  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// ===== design/tfa_daymod.sv =====
// ----------------------------------------------------------------------------
// Day modulo
// Reduces the sum modulo one day and splits off the hour.
// ----------------------------------------------------------------------------
module tfa_daymod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  tfa_pkg::tfa_ctl_t ctl_i,
  input  logic [31:0]       mag_i,
  input  logic              neg_i,
  output tfa_pkg::tfa_ctl_t ctl_o,
  output logic [22:0]       pos_o,
  output logic [4:0]        hours_o
);

  tfa_pkg::tfa_ctl_t c3_q, c4_q, c5_q;
  logic [66:0] qprod;
  logic [11:0] q3_q;
  logic [31:0] mag3_q;
  logic        neg3_q, neg4_q;
  logic [34:0] qday;
  logic [22:0] r4_q;
  logic [22:0] pos;
  logic [47:0] hprod;
  logic [22:0] p5_q;
  logic [4:0]  h5_q;

  // Stage 3: quotient by the day length through its reciprocal.
  assign qprod = 67'(mag_i) * 67'(tfa_pkg::M_DAY[ctl_i.rate]);

  // Stage 4: remainder of the magnitude.
  assign qday = 35'(q3_q) * 35'(tfa_pkg::DAY[c3_q.rate]);

  // Stage 5: fold a negative sum back into the day, then find the hour.
  always_comb begin
    if (neg4_q && (r4_q != 23'd0)) begin
      pos = tfa_pkg::DAY[c4_q.rate] - r4_q;
    end else begin
      pos = r4_q;
    end
    hprod = 48'(pos) * 48'(tfa_pkg::M_HR[c4_q.rate]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
    end else if (en_i) begin
      c3_q <= ctl_i;
      c4_q <= c3_q;
      c5_q <= c4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q3_q   <= qprod[66:55];
      mag3_q <= mag_i;
      neg3_q <= neg_i;
      r4_q   <= 23'(mag3_q - qday[31:0]);
      neg4_q <= neg3_q;
      p5_q   <= pos;
      h5_q   <= hprod[45:41];
    end
  end

  assign ctl_o   = c5_q;
  assign pos_o   = p5_q;
  assign hours_o = h5_q;

endmodule

// ===== design/tfa_split.sv =====
// ----------------------------------------------------------------------------
// Frame count split
// Turns a frame count within the day into minutes, seconds and frames.
// ----------------------------------------------------------------------------
module tfa_split (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  tfa_pkg::tfa_ctl_t ctl_i,
  input  logic [22:0]       pos_i,
  input  logic [4:0]        hours_i,
  output tfa_pkg::tfa_ctl_t ctl_o,
  output logic [4:0]        hours_o,
  output logic [5:0]        minutes_o,
  output logic [5:0]        seconds_o,
  output logic [5:0]        frames_o
);

  tfa_pkg::tfa_ctl_t c6_q, c7_q, c8_q, c9_q, c10_q, c11_q, c12_q;
  logic [4:0]  h6_q, h7_q, h8_q, h9_q, h10_q, h11_q, h12_q;

  // Stage 6: remainder within the hour.
  logic [35:0] hfph;
  logic [17:0] rem6_q;
  assign hfph = 36'(pos_i - 23'(23'(hours_i) * 23'(tfa_pkg::FPH[ctl_i.rate])));

  // Stage 7: minute (or ten-minute block) through its reciprocal.
  logic [41:0] tprod;
  logic [5:0]  t7_q;
  logic [17:0] rem7_q;
  assign tprod = 42'(rem6_q) * 42'(tfa_pkg::M_MIN[c6_q.rate]);

  // Stage 8: remainder within that minute or block.
  logic [15:0] rem8_q;
  logic [5:0]  t8_q;

  // Stage 9: minute within a ten-minute block for the drop rates.
  logic        drop8, dbl8;
  logic [15:0] base8, x8;
  logic        ge8;
  logic [33:0] dprod;
  logic        ge9_q;
  logic [15:0] x9_q, rem9_q;
  logic [3:0]  q9_q;
  logic [5:0]  t9_q;
  always_comb begin
    drop8 = tfa_pkg::is_drop(c8_q.rate);
    dbl8  = (c8_q.rate == tfa_pkg::RATE_D5994);
    base8 = dbl8 ? 16'd3600 : 16'd1800;
    ge8   = drop8 && (rem8_q >= base8);
    x8    = rem8_q - base8;
    dprod = 34'(x8) * 34'(tfa_pkg::M_DM[c8_q.rate]);
  end

  // Stage 10: minute, and the frame count left within it.
  logic        drop9, dbl9;
  logic [11:0] xr, y10_d;
  logic [5:0]  mm, m10_d, fdir_d;
  logic        direct_d;
  logic [11:0] y10_q;
  logic [5:0]  m10_q, fdir10_q, m11_q, fdir11_q;
  logic        direct10_q, sbase10_q, direct11_q, sbase11_q;
  always_comb begin
    drop9    = tfa_pkg::is_drop(c9_q.rate);
    dbl9     = (c9_q.rate == tfa_pkg::RATE_D5994);
    mm       = ge9_q ? 6'(q9_q) + 6'd1 : 6'd0;
    xr       = ge9_q ? 12'(x9_q - 16'(16'(q9_q) * 16'(tfa_pkg::D3[c9_q.rate]))) : 12'(rem9_q);
    m10_d    = drop9 ? 6'(t9_q * 6'd10 + mm) : t9_q;
    direct_d = ge9_q && (xr < (dbl9 ? 12'd56 : 12'd28));
    fdir_d   = 6'(xr + (dbl9 ? 12'd4 : 12'd2));
    y10_d    = ge9_q ? xr - (dbl9 ? 12'd56 : 12'd28) : xr;
  end

  // Stage 11: second through its reciprocal.
  logic [25:0] sprod;
  logic [5:0]  sq11_q;
  logic [11:0] y11_q;
  assign sprod = 26'(y10_q) * 26'(tfa_pkg::M_SEC[c10_q.rate]);

  // Stage 12: second and frame.
  logic [5:0] s_d, f_d, m12_q, s12_q, f12_q;
  always_comb begin
    if (direct11_q) begin
      s_d = 6'd0;
      f_d = fdir11_q;
    end else begin
      s_d = sq11_q + 6'(sbase11_q);
      f_d = 6'(y11_q - 12'(12'(sq11_q) * 12'(tfa_pkg::FPS[c11_q.rate])));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c6_q  <= '0;
      c7_q  <= '0;
      c8_q  <= '0;
      c9_q  <= '0;
      c10_q <= '0;
      c11_q <= '0;
      c12_q <= '0;
    end else if (en_i) begin
      c6_q  <= ctl_i;
      c7_q  <= c6_q;
      c8_q  <= c7_q;
      c9_q  <= c8_q;
      c10_q <= c9_q;
      c11_q <= c10_q;
      c12_q <= c11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h6_q       <= hours_i;
      rem6_q     <= hfph[17:0];
      h7_q       <= h6_q;
      t7_q       <= tprod[39:34];
      rem7_q     <= rem6_q;
      h8_q       <= h7_q;
      t8_q       <= t7_q;
      rem8_q     <= 16'(rem7_q - 18'(18'(t7_q) * 18'(tfa_pkg::D2[c7_q.rate])));
      h9_q       <= h8_q;
      t9_q       <= t8_q;
      ge9_q      <= ge8;
      x9_q       <= x8;
      rem9_q     <= rem8_q;
      q9_q       <= dprod[31:28];
      h10_q      <= h9_q;
      m10_q      <= m10_d;
      y10_q      <= y10_d;
      direct10_q <= direct_d;
      fdir10_q   <= fdir_d;
      sbase10_q  <= ge9_q;
      h11_q      <= h10_q;
      m11_q      <= m10_q;
      y11_q      <= y10_q;
      sq11_q     <= sprod[23:18];
      direct11_q <= direct10_q;
      fdir11_q   <= fdir10_q;
      sbase11_q  <= sbase10_q;
      h12_q      <= h11_q;
      m12_q      <= m11_q;
      s12_q      <= s_d;
      f12_q      <= f_d;
    end
  end

  assign ctl_o     = c12_q;
  assign hours_o   = h12_q;
  assign minutes_o = m12_q;
  assign seconds_o = s12_q;
  assign frames_o  = f12_q;

endmodule

// ===== design/timecode_frame_arithmetic.sv =====
// ----------------------------------------------------------------------------
// Timecode frame arithmetic
// Adds timecodes, adds a frame offset or gives a frame difference.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries a command, timecodes a and b and a signed frame
// offset; a transfer happens when in_valid_i is high and in_stall_o is low.
// Each transfer yields exactly one result transfer on the output channel,
// taken when out_valid_o is high and out_stall_i is low.
// The frame rate comes from rate_kind_i, written when rate_kind_we_i is high;
// it must only change while no item is in flight.
// The result is registered through the stages of tfa_front, tfa_daymod and
// tfa_split. A new item can enter every cycle unless the receiver stalls,
// so throughput is one item per cycle. The depth is set by the chain of
// constant divisions (day, hour, minute, second), each done by a reciprocal
// multiply in one stage and a multiply-back subtract in the next.
// When the receiver stalls with a result waiting, the whole pipeline freezes
// and in_stall_o rises in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and sets the rate to 30 frames non-drop.
// ----------------------------------------------------------------------------
module timecode_frame_arithmetic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rate_kind_we_i,
  input  logic [2:0]        rate_kind_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [4:0]        a_hours_i,
  input  logic [5:0]        a_minutes_i,
  input  logic [5:0]        a_seconds_i,
  input  logic [5:0]        a_frames_i,
  input  logic [4:0]        b_hours_i,
  input  logic [5:0]        b_minutes_i,
  input  logic [5:0]        b_seconds_i,
  input  logic [5:0]        b_frames_i,
  input  logic signed [31:0] frame_offset_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              status_o,
  output logic [4:0]        res_hours_o,
  output logic [5:0]        res_minutes_o,
  output logic [5:0]        res_seconds_o,
  output logic [5:0]        res_frames_o,
  output logic [1:0]        day_wrap_o,
  output logic signed [23:0] frame_difference_o
);

  logic [2:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= tfa_pkg::RATE_RESET;
    end else if (rate_kind_we_i) begin
      rate_q <= rate_kind_i;
    end
  end

  // The pipeline advances as a whole unless a finished result is held.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  tfa_pkg::tfa_ctl_t ctl_f, ctl_m, ctl_s;
  logic [31:0] mag;
  logic        neg;
  logic [22:0] pos;
  logic [4:0]  hrs_m, hrs_s;
  logic [5:0]  min_s, sec_s, frm_s;

  tfa_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .vld_i          (in_valid_i),
    .rate_i         (rate_q),
    .cmd_i          (cmd_i),
    .a_hours_i      (a_hours_i),
    .a_minutes_i    (a_minutes_i),
    .a_seconds_i    (a_seconds_i),
    .a_frames_i     (a_frames_i),
    .b_hours_i      (b_hours_i),
    .b_minutes_i    (b_minutes_i),
    .b_seconds_i    (b_seconds_i),
    .b_frames_i     (b_frames_i),
    .frame_offset_i (frame_offset_i),
    .ctl_o          (ctl_f),
    .mag_o          (mag),
    .neg_o          (neg)
  );

  tfa_daymod u_daymod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (ctl_f),
    .mag_i   (mag),
    .neg_i   (neg),
    .ctl_o   (ctl_m),
    .pos_o   (pos),
    .hours_o (hrs_m)
  );

  tfa_split u_split (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctl_i     (ctl_m),
    .pos_i     (pos),
    .hours_i   (hrs_m),
    .ctl_o     (ctl_s),
    .hours_o   (hrs_s),
    .minutes_o (min_s),
    .seconds_o (sec_s),
    .frames_o  (frm_s)
  );

  // Fields that the command does not use, and all fields of a rejected item,
  // read as zero.
  logic tc_out, diff_out;
  assign tc_out   = ctl_s.ok && (ctl_s.cmd != tfa_pkg::CMD_DIFF);
  assign diff_out = ctl_s.ok && (ctl_s.cmd == tfa_pkg::CMD_DIFF);

  assign out_valid_o        = ctl_s.vld;
  assign status_o           = !ctl_s.ok;
  assign res_hours_o        = tc_out ? hrs_s : 5'd0;
  assign res_minutes_o      = tc_out ? min_s : 6'd0;
  assign res_seconds_o      = tc_out ? sec_s : 6'd0;
  assign res_frames_o       = tc_out ? frm_s : 6'd0;
  assign day_wrap_o         = tc_out ? ctl_s.wrap : tfa_pkg::WRAP_NONE;
  assign frame_difference_o = diff_out ? $signed(ctl_s.diff) : 24'sd0;

  // A rejected item carries nothing but its status.
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> res_hours_o == 5'd0 && res_frames_o == 6'd0 &&
    day_wrap_o == tfa_pkg::WRAP_NONE && frame_difference_o == 24'sd0)
    else $error("rejected item carries nonzero fields");

  // The day reduction must leave a timecode inside the day.
  a_tc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> res_hours_o <= 5'd23 && res_minutes_o <= 6'd59 &&
    res_seconds_o <= 6'd59 && res_frames_o <= 6'd59)
    else $error("result timecode out of range");

  a_wrap_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> day_wrap_o != 2'd3)
    else $error("undefined day wrap code");

endmodule

// ===== dv/timecode_frame_arithmetic_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timecode frame arithmetic testbench
// Drives timecode sums, offset sums and differences at every frame rate and
// checks each result against an in-bench model of the timecode arithmetic.
// ----------------------------------------------------------------------------
module timecode_frame_arithmetic_test;

  // One input transfer and one result, as plain fields.
  typedef struct {
    logic [1:0]         cmd;
    logic [4:0]         ah;
    logic [5:0]         am, as_, af;
    logic [4:0]         bh;
    logic [5:0]         bm, bs, bf;
    logic signed [31:0] ofs;
  } tc_req_t;

  typedef struct {
    logic               status;
    logic [4:0]         hours;
    logic [5:0]         minutes, seconds, frames;
    logic [1:0]         wrap;
    logic signed [23:0] diff;
  } tc_res_t;

  localparam int LATENCY     = 12;
  localparam int IDLE_LIMIT  = 20000;
  localparam int LONG_STALL  = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic rate_kind_we_i = 1'b0;
  logic [2:0] rate_kind_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = '0;
  logic [4:0] a_hours_i = '0, b_hours_i = '0;
  logic [5:0] a_minutes_i = '0, a_seconds_i = '0, a_frames_i = '0;
  logic [5:0] b_minutes_i = '0, b_seconds_i = '0, b_frames_i = '0;
  logic signed [31:0] frame_offset_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic status_o;
  logic [4:0] res_hours_o;
  logic [5:0] res_minutes_o, res_seconds_o, res_frames_o;
  logic [1:0] day_wrap_o;
  logic signed [23:0] frame_difference_o;

  timecode_frame_arithmetic i_dut (
    .clk_i, .rst_ni, .rate_kind_we_i, .rate_kind_i,
    .in_valid_i, .in_stall_o, .cmd_i,
    .a_hours_i, .a_minutes_i, .a_seconds_i, .a_frames_i,
    .b_hours_i, .b_minutes_i, .b_seconds_i, .b_frames_i,
    .frame_offset_i, .out_valid_o, .out_stall_i, .status_o,
    .res_hours_o, .res_minutes_o, .res_seconds_o, .res_frames_o,
    .day_wrap_o, .frame_difference_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Rate the model believes is loaded; it changes only while idle.
  logic [2:0] cur_rate = tfa_pkg::RATE_RESET;
  tc_res_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;     // the long receiver hold-off is running
  bit stall_busy = 1'b1;   // share of stalled cycles is high in this phase

  // ---------------------------------------------------------------------------
  // Timecode model
  // ---------------------------------------------------------------------------
  function automatic longint rate_fps(logic [2:0] k);
    case (k)
      tfa_pkg::RATE_24: return 24;
      tfa_pkg::RATE_25: return 25;
      tfa_pkg::RATE_30, tfa_pkg::RATE_D2997: return 30;
      tfa_pkg::RATE_60, tfa_pkg::RATE_D5994: return 60;
      default: return 0;
    endcase
  endfunction

  function automatic longint rate_fph(logic [2:0] k);
    case (k)
      tfa_pkg::RATE_D2997: return 107892;
      tfa_pkg::RATE_D5994: return 215784;
      default: return rate_fps(k) * 3600;
    endcase
  endfunction

  function automatic bit is_drop_rate(logic [2:0] k);
    return (k == tfa_pkg::RATE_D2997) || (k == tfa_pkg::RATE_D5994);
  endfunction

  function automatic bit tc_ok(logic [2:0] k, int h, int m, int s, int f);
    int skip;
    if (rate_fps(k) == 0 || h > 23 || m > 59 || s > 59 || f >= rate_fps(k)) return 0;
    skip = (k == tfa_pkg::RATE_D5994) ? 4 : 2;
    // Drop-frame labels: the first frame numbers of second zero do not exist
    // unless the minute is a multiple of ten.
    if (is_drop_rate(k) && s == 0 && f < skip && m % 10 != 0)
      return 0;
    return 1;
  endfunction

  function automatic longint tc_count(logic [2:0] k, int h, int m, int s, int f);
    longint n, mul;
    n = h * rate_fph(k);
    if (is_drop_rate(k)) begin
      mul = (k == tfa_pkg::RATE_D5994) ? 2 : 1;
      n += (m / 10) * 17982 * mul;
      if (m % 10 > 0) n += (1800 + (m % 10 - 1) * 1798 - 2) * mul;
      n += s * rate_fps(k) + f;
    end else begin
      n += (m * 60 + s) * rate_fps(k) + f;
    end
    return n;
  endfunction

  function automatic void count_to_tc(logic [2:0] k, longint p, ref tc_res_t r);
    longint fps, mul, h, tens, mm, q, m, s, f;
    fps = rate_fps(k);
    h = p / rate_fph(k);
    p -= h * rate_fph(k);
    if (is_drop_rate(k)) begin
      mul = (k == tfa_pkg::RATE_D5994) ? 2 : 1;
      tens = p / (17982 * mul);
      p -= tens * 17982 * mul;
      if (p < 1800 * mul) begin
        mm = 0;
      end else begin
        q = (p - 1800 * mul) / (1798 * mul);
        mm = 1 + q;
        p -= 1800 * mul + q * 1798 * mul;
      end
      m = tens * 10 + mm;
      if (mm == 0) begin
        s = p / fps;
        f = p % fps;
      end else if (p < 28 * mul) begin
        s = 0;
        f = p + 2 * mul;
      end else begin
        s = 1 + (p - 28 * mul) / fps;
        f = (p - 28 * mul) % fps;
      end
    end else begin
      m = p / (60 * fps);
      p -= m * 60 * fps;
      s = p / fps;
      f = p % fps;
    end
    r.hours = h[4:0];
    r.minutes = m[5:0];
    r.seconds = s[5:0];
    r.frames = f[5:0];
  endfunction

  function automatic tc_res_t predict_timecode(tc_req_t q);
    tc_res_t r;
    longint pa, sum, day_len, wrapped;
    bit ok;
    r = '{status: 1'b0, hours: '0, minutes: '0, seconds: '0, frames: '0,
          wrap: tfa_pkg::WRAP_NONE, diff: '0};
    ok = q.cmd != 2'd3 && tc_ok(cur_rate, q.ah, q.am, q.as_, q.af);
    if (ok && q.cmd != tfa_pkg::CMD_ADD_OFS) ok = tc_ok(cur_rate, q.bh, q.bm, q.bs, q.bf);
    if (!ok) begin
      r.status = 1'b1;
      return r;
    end
    pa = tc_count(cur_rate, q.ah, q.am, q.as_, q.af);
    if (q.cmd == tfa_pkg::CMD_DIFF) begin
      sum = tc_count(cur_rate, q.bh, q.bm, q.bs, q.bf) - pa;
      r.diff = sum[23:0];
      return r;
    end
    day_len = 24 * rate_fph(cur_rate);
    sum = (q.cmd == tfa_pkg::CMD_ADD_TC) ? pa + tc_count(cur_rate, q.bh, q.bm, q.bs, q.bf)
                                         : pa + longint'(q.ofs);
    if (sum < 0) r.wrap = tfa_pkg::WRAP_UNDER;
    else if (sum >= day_len) r.wrap = tfa_pkg::WRAP_OVER;
    wrapped = sum % day_len;
    if (wrapped < 0) wrapped += day_len;
    count_to_tc(cur_rate, wrapped, r);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------
  task automatic send_request(tc_req_t q);
    in_valid_i     <= 1'b1;
    cmd_i          <= q.cmd;
    a_hours_i      <= q.ah;
    a_minutes_i    <= q.am;
    a_seconds_i    <= q.as_;
    a_frames_i     <= q.af;
    b_hours_i      <= q.bh;
    b_minutes_i    <= q.bm;
    b_seconds_i    <= q.bs;
    b_frames_i     <= q.bf;
    frame_offset_i <= q.ofs;
    pending_results.push_back(predict_timecode(q));
    // Hold the transfer until an edge sees valid high and stall low.
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Lowers valid after a burst and waits a random gap; a zero gap keeps the
  // channel busy so back-to-back transfers happen as well.
  task automatic sender_gap(bit bursty);
    int gap;
    if (!bursty || $urandom_range(0, 5) != 0) return;
    gap = $urandom_range(1, 6);
    in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic idle_after_send();
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic load_rate(logic [2:0] k);
    drain_results();
    rate_kind_we_i <= 1'b1;
    rate_kind_i    <= k;
    @(posedge clk_i);
    rate_kind_we_i <= 1'b0;
    cur_rate = k;
  endtask

  function automatic tc_req_t make_req(logic [1:0] c, int ah, int am, int as_, int af,
                                       int bh, int bm, int bs, int bf, int ofs);
    tc_req_t q;
    q.cmd = c;
    q.ah = ah; q.am = am; q.as_ = as_; q.af = af;
    q.bh = bh; q.bm = bm; q.bs = bs; q.bf = bf;
    q.ofs = ofs;
    return q;
  endfunction

  // A timecode for the loaded rate, legal in most cases, with edge values favored.
  function automatic void legal_tc(output logic [4:0] h, output logic [5:0] m,
                                   output logic [5:0] s, output logic [5:0] f);
    int fps;
    fps = (rate_fps(cur_rate) == 0) ? 30 : int'(rate_fps(cur_rate));
    h = ($urandom_range(0, 3) == 0) ? 5'(23 * $urandom_range(0, 1)) : 5'($urandom_range(0, 23));
    m = ($urandom_range(0, 3) == 0) ? 6'(59 * $urandom_range(0, 1)) : 6'($urandom_range(0, 59));
    s = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(0, 59));
    f = ($urandom_range(0, 3) == 0) ? 6'(fps - 1) : 6'($urandom_range(0, fps - 1));
    // Steer off labels that a drop-frame rate skips, most of the time.
    if (!tc_ok(cur_rate, h, m, s, f) && $urandom_range(0, 4) != 0) f = 6'(fps - 1);
  endfunction

  function automatic tc_req_t random_req();
    tc_req_t q;
    logic [31:0] raw;
    legal_tc(q.ah, q.am, q.as_, q.af);
    legal_tc(q.bh, q.bm, q.bs, q.bf);
    q.cmd = 2'($urandom_range(0, 2));
    raw = $urandom();
    case ($urandom_range(0, 3))
      0: q.ofs = $signed(raw);
      1: q.ofs = $signed(raw) >>> $urandom_range(8, 30);
      2: q.ofs = -(32'sd5184000 * $signed(32'($urandom_range(0, 3))));
      default: q.ofs = $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
    endcase
    // A share of noise: out-of-range fields or the unused command code.
    case ($urandom_range(0, 11))
      0: q.cmd = 2'd3;
      1: begin q.ah = 5'($urandom()); q.am = 6'($urandom()); end
      2: begin q.as_ = 6'($urandom()); q.af = 6'($urandom()); end
      3: begin q.bh = 5'($urandom()); q.bm = 6'($urandom());
               q.bs = 6'($urandom()); q.bf = 6'($urandom()); end
      default: ;
    endcase
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    load_rate(tfa_pkg::RATE_30);
    send_request(make_req(tfa_pkg::CMD_ADD_TC, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(tfa_pkg::CMD_ADD_TC, 23, 59, 59, 29, 0, 0, 0, 1, 0));
    send_request(make_req(tfa_pkg::CMD_ADD_TC, 23, 59, 59, 29, 23, 59, 59, 29, 0));
    send_request(make_req(tfa_pkg::CMD_ADD_OFS, 0, 0, 0, 0, 31, 63, 63, 63, -1));
    send_request(make_req(tfa_pkg::CMD_ADD_OFS, 0, 0, 0, 0, 0, 0, 0, 0, -2592000));
    send_request(make_req(tfa_pkg::CMD_ADD_OFS, 0, 0, 0, 0, 0, 0, 0, 0, -5184000));
    send_request(make_req(tfa_pkg::CMD_ADD_OFS, 12, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
    send_request(make_req(tfa_pkg::CMD_ADD_OFS, 12, 0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff));
    send_request(make_req(tfa_pkg::CMD_DIFF, 23, 59, 59, 29, 0, 0, 0, 0, 0));
    send_request(make_req(tfa_pkg::CMD_DIFF, 0, 0, 0, 0, 23, 59, 59, 29, 0));
    send_request(make_req(2'd3, 1, 1, 1, 1, 1, 1, 1, 1, 0));
    send_request(make_req(tfa_pkg::CMD_ADD_TC, 24, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(tfa_pkg::CMD_DIFF, 0, 60, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(tfa_pkg::CMD_DIFF, 0, 0, 0, 0, 0, 0, 60, 0, 0));
    send_request(make_req(tfa_pkg::CMD_ADD_TC, 0, 0, 0, 30, 0, 0, 0, 0, 0));
    load_rate(tfa_pkg::RATE_D2997);
    send_request(make_req(tfa_pkg::CMD_ADD_OFS, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(tfa_pkg::CMD_ADD_OFS, 0, 1, 0, 2, 0, 0, 0, 0, -1));
    send_request(make_req(tfa_pkg::CMD_ADD_OFS, 0, 10, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(tfa_pkg::CMD_ADD_OFS, 0, 40, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(tfa_pkg::CMD_ADD_OFS, 0, 0, 59, 29, 0, 0, 0, 0, 1));
    load_rate(tfa_pkg::RATE_D5994);
    send_request(make_req(tfa_pkg::CMD_DIFF, 0, 1, 0, 3, 0, 1, 0, 4, 0));
    send_request(make_req(tfa_pkg::CMD_ADD_OFS, 23, 59, 59, 59, 0, 0, 0, 0, 1));
    load_rate(3'd7);
    send_request(make_req(tfa_pkg::CMD_ADD_TC, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    load_rate(3'd6);
    send_request(make_req(tfa_pkg::CMD_DIFF, 1, 2, 3, 4, 1, 2, 3, 4, 0));
    idle_after_send();
  endtask

  // Random items at every rate, each rate in its own phase.
  task automatic test_random_rates(int per_rate);
    logic [2:0] order[8] = '{tfa_pkg::RATE_24, tfa_pkg::RATE_25, tfa_pkg::RATE_30,
                             tfa_pkg::RATE_60, tfa_pkg::RATE_D2997, tfa_pkg::RATE_D5994,
                             3'd6, tfa_pkg::RATE_D2997};
    int n;
    foreach (order[i]) begin
      load_rate(order[i]);
      stall_busy = (i % 2 == 0);
      n = (order[i] == 3'd6) ? 20 : per_rate;
      repeat (n) begin
        send_request(random_req());
        sender_gap(i != 3);
      end
      idle_after_send();
    end
  endtask

  // The receiver holds off while the sender keeps offering items, so the
  // pipeline fills and the input stall must rise.
  task automatic test_backpressure();
    load_rate(tfa_pkg::RATE_25);
    hold_off = 1'b1;
    repeat (40) send_request(random_req());
    idle_after_send();
    wait (!hold_off);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        for (hold = 0; hold < LONG_STALL; hold++) @(posedge clk_i);
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else if (stall_busy) begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end else begin
        out_stall_i <= ($urandom_range(0, 15) == 0);
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
  endtask

  initial begin
    tc_res_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
          if (res_hours_o !== want.hours) report_mismatch("hours", res_hours_o, want.hours);
          if (res_minutes_o !== want.minutes)
            report_mismatch("minutes", res_minutes_o, want.minutes);
          if (res_seconds_o !== want.seconds)
            report_mismatch("seconds", res_seconds_o, want.seconds);
          if (res_frames_o !== want.frames) report_mismatch("frames", res_frames_o, want.frames);
          if (day_wrap_o !== want.wrap) report_mismatch("day wrap", day_wrap_o, want.wrap);
          if (frame_difference_o !== want.diff)
            report_mismatch("difference", frame_difference_o, want.diff);
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || rate_kind_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_rates(100);
    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
